// File: rtl/core/cor_pkg.sv
// Camera orbit rotation: shared types, codes and constants.
// No dependencies; used by cor_mul, cor_divsqrt, cor_cordic and the top unit.
package cor_pkg;

  localparam int MW = 36;
  localparam int PW = 72;

  typedef logic signed [MW-1:0] cor_op_t;
  typedef logic signed [PW-1:0] cor_prod_t;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_LEFT = 2'd1;
  localparam logic [1:0] ACT_UP   = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  localparam logic signed [MW-1:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic signed [MW-1:0] DEG_TO_RAD  = 36'sd74961321;
  localparam logic signed [MW-1:0] Q30_ONE     = 36'sd1073741824;

  localparam logic signed [27:0] DEG90  = 28'sd5898240;
  localparam logic signed [27:0] DEG180 = 28'sd11796480;
  localparam logic signed [27:0] DEG360 = 28'sd23592960;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } cor_ds_req_t;

  function automatic logic [31:0] cor_atan(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] cor_next1(input logic [1:0] k);
    logic [1:0] v;
    unique case (k)
      2'd0: v = 2'd1;
      2'd1: v = 2'd2;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] cor_next2(input logic [1:0] k);
    logic [1:0] v;
    unique case (k)
      2'd0: v = 2'd2;
      2'd1: v = 2'd0;
      default: v = 2'd1;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] cor_sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/cor_if.sv
// Camera orbit rotation: command and result channel interfaces.
// Valid/ready handshake with payload; no dependencies.
interface cor_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [25:0] angle_deg;
  logic signed [31:0] load_eye_x;
  logic signed [31:0] load_eye_y;
  logic signed [31:0] load_eye_z;
  logic signed [31:0] load_up_x;
  logic signed [31:0] load_up_y;
  logic signed [31:0] load_up_z;
  modport source (output valid, action, angle_deg, load_eye_x, load_eye_y, load_eye_z,
                  load_up_x, load_up_y, load_up_z, input ready);
  modport sink (input valid, action, angle_deg, load_eye_x, load_eye_y, load_eye_z,
                load_up_x, load_up_y, load_up_z, output ready);
endinterface

interface cor_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;
  logic               degenerate;
  modport source (output valid, eye_x, eye_y, eye_z, up_x, up_y, up_z, degenerate,
                  input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, up_x, up_y, up_z, degenerate,
                output ready);
endinterface

// File: rtl/core/cor_mul.sv
// Camera orbit rotation: shared signed multiplier with registered product.
// Depends on cor_pkg.
module cor_mul (
  input  logic             clk,
  input  logic             en,
  input  cor_pkg::cor_op_t a,
  input  cor_pkg::cor_op_t b,
  output cor_pkg::cor_prod_t prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// File: rtl/core/cor_divsqrt.sv
// Camera orbit rotation: shared bit-serial square root and divider.
// Sqrt of a 64-bit value in 32 steps, (num << 30) / den in 31 steps. Depends on cor_pkg.
module cor_divsqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  cor_pkg::cor_ds_req_t req,
  input  logic [63:0]          sq_in,
  input  logic [30:0]          num,
  input  logic [31:0]          den_in,
  output logic                 done,
  output logic [31:0]          result
);

  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd30;

  logic        busy;
  logic        mode;
  logic [4:0]  cnt;
  logic [63:0] sv;
  logic [63:0] res;
  logic [33:0] rem;
  logic [30:0] nb;
  logic [30:0] q;
  logic [31:0] den;
  logic [63:0] sbit;
  logic [63:0] strial;
  logic [33:0] dt;
  logic        dge;
  logic [4:0]  last;

  assign sbit   = 64'd1 << (6'd62 - {cnt, 1'b0});
  assign strial = res + sbit;
  assign dt     = {rem[32:0], nb[30]};
  assign dge    = dt >= {2'b00, den};
  assign last   = mode ? SQRT_LAST : DIV_LAST;
  assign result = mode ? res[31:0] : {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        mode <= req.sqrt_mode;
        cnt  <= '0;
        sv   <= sq_in;
        res  <= '0;
        rem  <= {4'b0000, num[30:1]};
        nb   <= {num[0], 30'd0};
        q    <= '0;
        den  <= den_in;
      end else if (busy) begin
        if (mode) begin
          if (sv >= strial) begin
            sv  <= sv - strial;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
        end else begin
          rem <= dge ? dt - {2'b00, den} : dt;
          q   <= {q[29:0], dge};
          nb  <= nb << 1;
        end
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 5'd1;
      end
    end
  end

endmodule

// File: rtl/core/cor_cordic.sv
// Camera orbit rotation: rotation-mode CORDIC, one step per cycle, Q6.30.
// Gives gain-corrected cosine and sine of z0. Depends on cor_pkg.
module cor_cordic #(
  parameter int ITERS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cor_pkg::cor_op_t z0,
  output logic             done,
  output cor_pkg::cor_op_t x,
  output cor_pkg::cor_op_t y
);

  localparam int NSTEPS = (ITERS < 30) ? ITERS : 30;
  localparam logic [4:0] LAST = 5'(NSTEPS - 1);

  logic             busy;
  logic [4:0]       i;
  cor_pkg::cor_op_t z;
  cor_pkg::cor_op_t dx;
  cor_pkg::cor_op_t dy;
  cor_pkg::cor_op_t at;

  assign dx = x >>> i;
  assign dy = y >>> i;
  assign at = cor_pkg::cor_op_t'(cor_pkg::cor_atan(i));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= cor_pkg::CORDIC_GAIN;
        y    <= '0;
        z    <= z0;
        i    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!z[cor_pkg::MW-1]) begin
          x <= x - dy;
          y <= y + dx;
          z <= z - at;
        end else begin
          x <= x + dy;
          y <= y - dx;
          z <= z + at;
        end
        if (i == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        i <= i + 5'd1;
      end
    end
  end

endmodule

// File: rtl/core/camera_orbit_rotation_unit.sv
// Camera orbit rotation unit: eye/up state, sequencer and Rodrigues rotation.
// Depends on cor_pkg, cor_if, cor_mul, cor_divsqrt and cor_cordic.
//
// Usage: one command per transfer on cmd (load both vectors, orbit left about
// up, orbit up about eye x up, or no-op); each command gives exactly one
// transfer on rsp with the state after it and the degenerate flag.
// A load or no-op goes from idle straight to the result stage; a zero-length
// axis ends early. Run time is set by the shared 36x36 multiplier (40
// products for orbit left, 58 for orbit up), the bit-serial root and divider
// (one root and three divisions per normalization, done once or twice), the
// CORDIC and the one-bit normalizing shifter.
// One command is in work at a time; cmd.ready is high only when idle.
// Reset (rst, synchronous) sets eye to (0,0,5) and up to (0,1,0) and drops any
// pending result. A stalled rsp holds its result in the output register; the
// next command is taken meanwhile but its result waits until that transfer.
module camera_orbit_rotation_unit #(
  parameter int FRAC_BITS    = 24,
  parameter int CORDIC_ITERS = 24
) (
  input logic       clk,
  input logic       rst,
  cor_cmd_if.sink   cmd,
  cor_res_if.source rsp
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CROSS  = 12'b000000000010,
    S_NORM   = 12'b000000000100,
    S_SQSUM  = 12'b000000001000,
    S_SQRT   = 12'b000000010000,
    S_DIV    = 12'b000000100000,
    S_RADMUL = 12'b000001000000,
    S_CORDIC = 12'b000010000000,
    S_ROT    = 12'b000100000000,
    S_APPLY  = 12'b001000000000,
    S_UPFIX  = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [63:0] HALF = (64'sd1 <<< SH) >>> 1;
  localparam logic signed [31:0] EYE_Z_RST = cor_pkg::cor_sat32(64'sd5 <<< FRAC_BITS);
  localparam logic signed [31:0] UP_Y_RST  = cor_pkg::cor_sat32(64'sd1 <<< FRAC_BITS);

  state_t state;

  logic signed [31:0] eye [3];
  logic signed [31:0] up [3];
  logic        [63:0] vec [3];
  logic               vneg [3];
  cor_pkg::cor_op_t   ax [3];
  logic signed [63:0] acc_e [3];
  logic signed [63:0] acc_u [3];
  logic signed [31:0] o_eye [3];
  logic signed [31:0] o_up [3];
  logic               o_deg;
  logic               res_valid;

  logic        [63:0] sum;
  logic        [31:0] rroot;
  cor_pkg::cor_op_t   cval;
  cor_pkg::cor_op_t   sval;
  cor_pkg::cor_op_t   t;
  cor_pkg::cor_op_t   r;
  cor_pkg::cor_op_t   zin;
  logic signed [63:0] tmp64;
  logic signed [27:0] ang;
  logic               flip;
  logic        [1:0]  act;
  logic               pass;
  logic               deg;
  logic        [1:0]  k;
  logic        [1:0]  ii;
  logic        [1:0]  jj;
  logic        [2:0]  m;
  logic               ph;

  cor_pkg::cor_ds_req_t ds_req;
  logic                 ds_done;
  logic        [31:0]   ds_result;
  logic                 cor_start;
  logic                 cor_done;
  cor_pkg::cor_op_t     cor_x;
  cor_pkg::cor_op_t     cor_y;

  logic                 mul_en;
  cor_pkg::cor_op_t     mul_a;
  cor_pkg::cor_op_t     mul_b;
  cor_pkg::cor_prod_t   prod;
  cor_pkg::cor_prod_t   prod_s30;
  cor_pkg::cor_prod_t   prod_s18;
  logic signed [63:0]   prod_lo;
  logic signed [64:0]   cross_d;
  cor_pkg::cor_op_t     kval;
  logic        [63:0]   vor;
  logic signed [27:0]   a0;
  logic signed [27:0]   a1;
  logic signed [27:0]   a2;
  logic                 aflip;
  cor_pkg::cor_op_t     qv;
  logic signed [63:0]   upr [3];

  assign prod_s30 = prod >>> 30;
  assign prod_s18 = prod >>> 18;
  assign prod_lo  = prod[63:0];
  assign cross_d  = 65'(tmp64) - 65'(prod_lo);
  assign vor      = vec[0] | vec[1] | vec[2];
  assign qv       = cor_pkg::cor_op_t'(ds_result);

  always_comb begin
    a0 = 28'(cmd.angle_deg);
    if (a0 > cor_pkg::DEG180) begin
      a1 = a0 - cor_pkg::DEG360;
    end else if (a0 < -cor_pkg::DEG180) begin
      a1 = a0 + cor_pkg::DEG360;
    end else begin
      a1 = a0;
    end
    aflip = 1'b0;
    if (a1 > cor_pkg::DEG90) begin
      a2    = a1 - cor_pkg::DEG180;
      aflip = 1'b1;
    end else if (a1 < -cor_pkg::DEG90) begin
      a2    = a1 + cor_pkg::DEG180;
      aflip = 1'b1;
    end else begin
      a2 = a1;
    end
  end

  always_comb begin
    unique case ({ii, jj})
      4'b0001: kval = -ax[2];
      4'b0010: kval = ax[1];
      4'b0100: kval = ax[2];
      4'b0110: kval = -ax[0];
      4'b1000: kval = -ax[1];
      4'b1001: kval = ax[0];
      default: kval = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      upr[i] = (64'(ax[i]) + HALF) >>> SH;
    end
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = !ph;
    unique case (state)
      S_CROSS: begin
        if (m == 3'd0) begin
          mul_a = cor_pkg::cor_op_t'(eye[cor_pkg::cor_next1(k)]);
          mul_b = cor_pkg::cor_op_t'(up[cor_pkg::cor_next2(k)]);
        end else begin
          mul_a = cor_pkg::cor_op_t'(eye[cor_pkg::cor_next2(k)]);
          mul_b = cor_pkg::cor_op_t'(up[cor_pkg::cor_next1(k)]);
        end
      end
      S_SQSUM: begin
        mul_a = {5'd0, vec[k][30:0]};
        mul_b = {5'd0, vec[k][30:0]};
      end
      S_RADMUL: begin
        mul_a = cor_pkg::cor_op_t'(ang);
        mul_b = cor_pkg::DEG_TO_RAD;
      end
      S_ROT: begin
        unique case (m)
          3'd0: begin
            mul_a = ax[ii];
            mul_b = ax[jj];
          end
          3'd1: begin
            mul_a = t;
            mul_b = cor_pkg::Q30_ONE - cval;
          end
          3'd2: begin
            mul_a = sval;
            mul_b = kval;
          end
          3'd3: begin
            mul_a = r;
            mul_b = cor_pkg::cor_op_t'(eye[jj]);
          end
          default: begin
            mul_a = r;
            mul_b = cor_pkg::cor_op_t'(up[jj]);
          end
        endcase
      end
      default: mul_en = 1'b0;
    endcase
  end

  cor_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  cor_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .req    (ds_req),
    .sq_in  (sum),
    .num    (vec[k][30:0]),
    .den_in (rroot),
    .done   (ds_done),
    .result (ds_result)
  );

  cor_cordic #(
    .ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .z0    (zin),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y)
  );

  assign cmd.ready      = (state == S_IDLE);
  assign rsp.valid      = res_valid;
  assign rsp.eye_x      = o_eye[0];
  assign rsp.eye_y      = o_eye[1];
  assign rsp.eye_z      = o_eye[2];
  assign rsp.up_x       = o_up[0];
  assign rsp.up_y       = o_up[1];
  assign rsp.up_z       = o_up[2];
  assign rsp.degenerate = o_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      eye[0]    <= '0;
      eye[1]    <= '0;
      eye[2]    <= EYE_Z_RST;
      up[0]     <= '0;
      up[1]     <= UP_Y_RST;
      up[2]     <= '0;
      res_valid <= 1'b0;
      ds_req    <= '0;
      cor_start <= 1'b0;
      ph        <= 1'b0;
    end else begin
      ds_req    <= '0;
      cor_start <= 1'b0;
      if (res_valid && rsp.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act  <= cmd.action;
            ang  <= a2;
            flip <= aflip;
            deg  <= 1'b0;
            pass <= 1'b0;
            ph   <= 1'b0;
            k    <= '0;
            m    <= '0;
            unique case (cmd.action)
              cor_pkg::ACT_LOAD: begin
                eye[0] <= cmd.load_eye_x;
                eye[1] <= cmd.load_eye_y;
                eye[2] <= cmd.load_eye_z;
                up[0]  <= cmd.load_up_x;
                up[1]  <= cmd.load_up_y;
                up[2]  <= cmd.load_up_z;
                state  <= S_DONE;
              end
              cor_pkg::ACT_LEFT: begin
                for (int i = 0; i < 3; i++) begin
                  vneg[i] <= up[i][31];
                  vec[i]  <= up[i][31] ? 64'(-64'(up[i])) : 64'(64'(up[i]));
                end
                state <= S_NORM;
              end
              cor_pkg::ACT_UP: state <= S_CROSS;
              cor_pkg::ACT_NOP: state <= S_DONE;
            endcase
          end
        end
        S_CROSS: begin
          ph <= !ph;
          if (ph) begin
            if (m == 3'd0) begin
              tmp64 <= prod_lo;
              m     <= 3'd1;
            end else begin
              vneg[k] <= cross_d[64];
              vec[k]  <= cross_d[64] ? 64'(-cross_d) : cross_d[63:0];
              m       <= 3'd0;
              if (k == 2'd2) begin
                k     <= '0;
                state <= S_NORM;
              end else begin
                k <= k + 2'd1;
              end
            end
          end
        end
        S_NORM: begin
          if (vor == 64'd0) begin
            if (!pass) begin
              deg <= 1'b1;
            end else begin
              for (int i = 0; i < 3; i++) up[i] <= '0;
            end
            state <= S_DONE;
          end else if (|vor[63:31]) begin
            for (int i = 0; i < 3; i++) vec[i] <= vec[i] >> 1;
          end else if (!vor[30]) begin
            for (int i = 0; i < 3; i++) vec[i] <= vec[i] << 1;
          end else begin
            sum   <= '0;
            k     <= '0;
            ph    <= 1'b0;
            state <= S_SQSUM;
          end
        end
        S_SQSUM: begin
          ph <= !ph;
          if (ph) begin
            sum <= sum + prod_lo;
            if (k == 2'd2) begin
              k      <= '0;
              ds_req <= '{start: 1'b1, sqrt_mode: 1'b1};
              state  <= S_SQRT;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_SQRT: begin
          if (ds_done) begin
            rroot  <= ds_result;
            ds_req <= '{start: 1'b1, sqrt_mode: 1'b0};
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (ds_done) begin
            ax[k] <= vneg[k] ? -qv : qv;
            if (k == 2'd2) begin
              k     <= '0;
              ph    <= 1'b0;
              state <= pass ? S_UPFIX : S_RADMUL;
            end else begin
              k      <= k + 2'd1;
              ds_req <= '{start: 1'b1, sqrt_mode: 1'b0};
            end
          end
        end
        S_RADMUL: begin
          ph <= !ph;
          if (ph) begin
            zin       <= prod_s18[cor_pkg::MW-1:0];
            cor_start <= 1'b1;
            state     <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cor_done) begin
            cval  <= flip ? -cor_x : cor_x;
            sval  <= flip ? -cor_y : cor_y;
            ii    <= '0;
            jj    <= '0;
            m     <= '0;
            ph    <= 1'b0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          ph <= !ph;
          if (ph) begin
            unique case (m)
              3'd0: begin
                t <= prod_s30[cor_pkg::MW-1:0];
                m <= 3'd1;
              end
              3'd1: begin
                r <= ((ii == jj) ? cval : cor_pkg::cor_op_t'(0)) + prod_s30[cor_pkg::MW-1:0];
                m <= 3'd2;
              end
              3'd2: begin
                r <= r + prod_s30[cor_pkg::MW-1:0];
                m <= 3'd3;
              end
              3'd3: begin
                acc_e[ii] <= ((jj == 2'd0) ? 64'sd0 : acc_e[ii]) + prod_lo;
                m         <= (act == cor_pkg::ACT_UP) ? 3'd4 : 3'd0;
              end
              default: begin
                acc_u[ii] <= ((jj == 2'd0) ? 64'sd0 : acc_u[ii]) + prod_lo;
                m         <= 3'd0;
              end
            endcase
            if ((m == 3'd4) || ((m == 3'd3) && (act != cor_pkg::ACT_UP))) begin
              if (jj == 2'd2) begin
                jj <= '0;
                if (ii == 2'd2) begin
                  state <= S_APPLY;
                end else begin
                  ii <= ii + 2'd1;
                end
              end else begin
                jj <= jj + 2'd1;
              end
            end
          end
        end
        S_APPLY: begin
          for (int i = 0; i < 3; i++) begin
            eye[i] <= cor_pkg::cor_sat32(acc_e[i] >>> 30);
          end
          if (act == cor_pkg::ACT_UP) begin
            for (int i = 0; i < 3; i++) begin
              vneg[i] <= acc_u[i][63];
              vec[i]  <= acc_u[i][63] ? 64'(-acc_u[i]) : 64'(acc_u[i]);
            end
            pass  <= 1'b1;
            state <= S_NORM;
          end else begin
            state <= S_DONE;
          end
        end
        S_UPFIX: begin
          for (int i = 0; i < 3; i++) begin
            up[i] <= cor_pkg::cor_sat32(upr[i]);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || rsp.ready) begin
            for (int i = 0; i < 3; i++) begin
              o_eye[i] <= eye[i];
              o_up[i]  <= up[i];
            end
            o_deg     <= deg;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
